// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the core module of the tag nesting checker.
// No dependencies; define ASSERT_OFF to compile all checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication or plain property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== hw/rtl/mtnc_pkg.sv =====
// Package of the markup tag nesting checker: sizes, codes, payload types.
// No dependencies; used by every RTL module of the block.
package mtnc_pkg;

  localparam int STACK_DEPTH  = 16;
  localparam int MAX_NAME_LEN = 16;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W  = $clog2(MAX_NAME_LEN + 1);
  localparam int ROW_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int COL_W  = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int ADDR_W = ((STACK_DEPTH * MAX_NAME_LEN) > 1) ?
                          $clog2(STACK_DEPTH * MAX_NAME_LEN) : 1;

  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_GT    = 8'h3E;

  typedef enum logic [1:0] {
    MODE_OUTSIDE,
    MODE_AFTER_LT,
    MODE_OPEN_NAME,
    MODE_CLOSE_NAME
  } scan_mode_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MISMATCH = 3'd1,
    ERR_EMPTY    = 3'd2,
    ERR_OVERFLOW = 3'd3,
    ERR_TOO_LONG = 3'd4
  } err_code_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_doc;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] nest_depth;
    logic       failed;
    logic       doc_done;
  } out_item_t;

  // Flat name store address of one byte of one stack row.
  function automatic logic [ADDR_W-1:0] store_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    store_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_NAME_LEN) + ADDR_W'(col));
  endfunction

endpackage

// ===== hw/rtl/mtnc_out_skid.sv =====
// Two-entry result buffer (output register plus skid register).
// Depends on mtnc_pkg for the result transaction type.
module mtnc_out_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mtnc_pkg::out_item_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output mtnc_pkg::out_item_t out_data
);
  import mtnc_pkg::*;

  logic      main_valid_r;
  logic      skid_valid_r;
  out_item_t main_data_r;
  out_item_t skid_data_r;
  logic      pop;

  assign pop       = main_valid_r && out_ready;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_data_r <= push_data;
      end else begin
        skid_data_r <= push_data;
      end
    end
  end

endmodule

// ===== hw/rtl/markup_tag_nesting_checker_core.sv =====
// Top level of the markup tag nesting checker.
// Depends on mtnc_pkg, mtnc_out_skid and assert_macros.svh.
//
// Usage:
//   The input channel (in_valid, in_ready, in_data) carries one document byte
//   per transaction together with an end-of-document flag. The result channel
//   (out_valid, out_ready, out_data) returns exactly one transaction per input
//   byte: the latched error status, the current nesting depth, a sticky fail
//   flag and the echoed end-of-document flag.
//   Each result is registered into the output buffer at the accepting edge.
//   Throughput is one byte per cycle while in_ready is high; the tag state is
//   updated as each byte is accepted, and the stored top name byte that a
//   closing tag compares against is prefetched from the name store,
//   addressed from the next state, so a registered read never stalls a byte.
//   A two-entry output buffer lets one more byte in while a result waits; when
//   the receiver stalls for longer, in_ready drops until a slot frees up.
//   Synchronous active-low reset returns the scanner to "outside any tag" with
//   an empty stack and no error. The name store and length table are not
//   cleared; only entries written by a completed opening tag are ever read.
//   After the first error all bytes are ignored and the status stays frozen
//   until reset. Open tags left at the end of a document are not an error.
`include "assert_macros.svh"
module markup_tag_nesting_checker_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mtnc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mtnc_pkg::out_item_t out_data
);
  import mtnc_pkg::*;

  // Scanner state.
  scan_mode_t       mode_r,  mode_nxt;
  logic [CNT_W-1:0] cnt_r,   cnt_nxt;
  logic [IDX_W-1:0] idx_r,   idx_nxt;
  logic             match_r, match_nxt;
  err_code_t        err_r,   err_nxt;

  // Name store (one row per stack level) and the per-row name length table.
  logic [7:0]       name_mem [STACK_DEPTH*MAX_NAME_LEN];
  logic [7:0]       rd_data_r;
  logic [IDX_W-1:0] len_r [STACK_DEPTH];

  logic             in_acc;
  logic             skid_full;
  logic [7:0]       c;
  logic [IDX_W-1:0] idx_eff;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] top_nxt;
  logic [IDX_W-1:0] len_top;
  logic             open_go;
  logic             st_we;
  logic [ADDR_W-1:0] st_waddr;
  logic [ADDR_W-1:0] st_raddr;
  logic             len_we;
  out_item_t        res;

  assign in_ready = !skid_full;
  assign in_acc   = in_valid && in_ready;
  assign c        = in_data.text_char;
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign len_top  = len_r[cnt_m1[ROW_W-1:0]];

  // The byte right after '<' always starts a name at position zero.
  assign idx_eff  = (mode_r == MODE_AFTER_LT) ? '0 : idx_r;

  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    match_nxt = match_r;
    err_nxt   = err_r;
    open_go   = 1'b0;
    st_we     = 1'b0;
    len_we    = 1'b0;
    st_waddr  = store_addr(cnt_r[ROW_W-1:0], idx_eff[COL_W-1:0]);

    if (in_acc && err_r == ERR_NONE) begin
      unique case (mode_r)
        MODE_OUTSIDE: begin
          if (c == CHAR_LT) begin
            mode_nxt = MODE_AFTER_LT;
          end
        end
        MODE_AFTER_LT: begin
          idx_nxt   = '0;
          match_nxt = 1'b1;
          if (c == CHAR_SLASH) begin
            if (cnt_r == '0) begin
              err_nxt = ERR_EMPTY;
            end else begin
              mode_nxt = MODE_CLOSE_NAME;
            end
          end else if (cnt_r >= CNT_W'(STACK_DEPTH)) begin
            err_nxt = ERR_OVERFLOW;
          end else begin
            mode_nxt = MODE_OPEN_NAME;
            open_go  = 1'b1;
          end
        end
        MODE_OPEN_NAME: begin
          open_go = 1'b1;
        end
        MODE_CLOSE_NAME: begin
          if (c == CHAR_GT) begin
            if (match_r && idx_r == len_top) begin
              cnt_nxt  = cnt_m1;
              mode_nxt = MODE_OUTSIDE;
            end else begin
              err_nxt = ERR_MISMATCH;
            end
          end else if (idx_r >= IDX_W'(MAX_NAME_LEN)) begin
            err_nxt = ERR_TOO_LONG;
          end else begin
            // rd_data_r holds the top name byte at idx_r, fetched last cycle.
            if (idx_r >= len_top || rd_data_r != c) begin
              match_nxt = 1'b0;
            end
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        default: begin
          mode_nxt = MODE_OUTSIDE;
        end
      endcase

      // Opening tag byte: end the name, flag a long name, or store the byte.
      if (open_go) begin
        if (c == CHAR_GT) begin
          len_we   = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
          mode_nxt = MODE_OUTSIDE;
        end else if (idx_eff >= IDX_W'(MAX_NAME_LEN)) begin
          err_nxt = ERR_TOO_LONG;
        end else begin
          st_we   = 1'b1;
          idx_nxt = idx_eff + IDX_W'(1);
        end
      end
    end
  end

  // Prefetch the byte the next closing-name character will be compared with.
  assign top_nxt  = cnt_nxt - CNT_W'(1);
  assign st_raddr = store_addr(top_nxt[ROW_W-1:0], idx_nxt[COL_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OUTSIDE;
      cnt_r   <= '0;
      idx_r   <= '0;
      match_r <= 1'b1;
      err_r   <= ERR_NONE;
    end else begin
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      match_r <= match_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      name_mem[st_waddr] <= c;
    end
    rd_data_r <= name_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_r[cnt_r[ROW_W-1:0]] <= idx_eff;
    end
  end

  always_comb begin
    res.status     = err_nxt;
    res.nest_depth = 5'(cnt_nxt);
    res.failed     = (err_nxt != ERR_NONE);
    res.doc_done   = in_data.end_of_doc;
  end

  mtnc_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (res),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Once an error is latched, the error code and the stack depth stay frozen.
  `ASSERT_CLK(a_err_sticky, clk, rst_n,
              (err_r != ERR_NONE) |=> (err_r == $past(err_r) && cnt_r == $past(cnt_r)))
  // The stack never holds more names than it has rows.
  `ASSERT_NEVER(a_cnt_bound, clk, rst_n, cnt_r > CNT_W'(STACK_DEPTH))
  // No name byte is stored after an error or while the stack is full.
  `ASSERT_NEVER(a_no_write_frozen, clk, rst_n,
                st_we && (err_r != ERR_NONE || cnt_r >= CNT_W'(STACK_DEPTH)))
  // Input back-pressure only happens while a result is waiting on the output.
  `ASSERT_CLK(a_ready_when_drained, clk, rst_n, !in_ready |-> out_valid)

endmodule

// ===== dv/mtnc_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker of the tag nesting checker testbench: predicts the status of
// every accepted byte and compares it with the result channel, field by field.
// Depends on mtnc_pkg for payload types, sizes, characters and codes.
module mtnc_result_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mtnc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mtnc_pkg::out_item_t out_data,
  output int                  mismatches,
  output int                  outstanding,
  output int                  results_checked,
  output int                  deepest,
  output mtnc_pkg::err_code_t latched_error
);
  import mtnc_pkg::*;

  scan_mode_t mode;
  logic [7:0] tag_text [STACK_DEPTH][MAX_NAME_LEN];
  logic [4:0] tag_len [STACK_DEPTH];
  logic [4:0] depth;
  logic [4:0] idx;
  logic       same_so_far;
  err_code_t  err;
  out_item_t  due_results [$];

  // Advances the tag scanner by one byte and returns the status it reports.
  task automatic scan_byte(input in_item_t item, output out_item_t res);
    logic [7:0] c;
    logic [4:0] top;
    logic       in_open;
    c = item.text_char;
    top = depth - 5'd1;
    in_open = (mode == MODE_OPEN_NAME);
    if (err == ERR_NONE) begin
      case (mode)
        MODE_OUTSIDE: begin
          if (c == CHAR_LT) mode = MODE_AFTER_LT;
        end
        MODE_AFTER_LT: begin
          idx = '0;
          same_so_far = 1'b1;
          if (c == CHAR_SLASH) begin
            if (depth == 0) err = ERR_EMPTY;
            else mode = MODE_CLOSE_NAME;
          end else if (depth >= STACK_DEPTH) begin
            err = ERR_OVERFLOW;
          end else begin
            mode = MODE_OPEN_NAME;
            in_open = 1'b1;
          end
        end
        MODE_CLOSE_NAME: begin
          if (c == CHAR_GT) begin
            if (same_so_far && idx == tag_len[top]) begin
              depth = top;
              mode = MODE_OUTSIDE;
            end else begin
              err = ERR_MISMATCH;
            end
          end else if (idx >= MAX_NAME_LEN) begin
            err = ERR_TOO_LONG;
          end else begin
            if (idx >= tag_len[top] || tag_text[top][idx] != c) same_so_far = 1'b0;
            idx = idx + 5'd1;
          end
        end
        default: ;
      endcase
      if (in_open) begin
        if (c == CHAR_GT) begin
          tag_len[depth] = idx;
          depth = depth + 5'd1;
          mode = MODE_OUTSIDE;
        end else if (idx >= MAX_NAME_LEN) begin
          err = ERR_TOO_LONG;
        end else begin
          tag_text[depth][idx] = c;
          idx = idx + 5'd1;
        end
      end
    end
    res.status = err;
    res.nest_depth = depth;
    res.failed = (err != ERR_NONE);
    res.doc_done = item.end_of_doc;
  endtask

  task automatic compare_field(input string field, input logic [4:0] want,
                               input logic [4:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t next_res;
    if (!rst_n) begin
      mode = MODE_OUTSIDE;
      depth = '0;
      idx = '0;
      same_so_far = 1'b1;
      err = ERR_NONE;
      due_results.delete();
      mismatches = 0;
      outstanding = 0;
      results_checked = 0;
      deepest = 0;
      latched_error = ERR_NONE;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, got %p", $time, out_data);
        end else begin
          want = due_results.pop_front();
          compare_field("status", 5'(want.status), 5'(out_data.status));
          compare_field("nest_depth", want.nest_depth, out_data.nest_depth);
          compare_field("failed", 5'(want.failed), 5'(out_data.failed));
          compare_field("doc_done", 5'(want.doc_done), 5'(out_data.doc_done));
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        scan_byte(in_data, next_res);
        due_results.push_back(next_res);
        if (int'(depth) > deepest) deepest = int'(depth);
        latched_error = err;
      end
      outstanding = due_results.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Top of the tag nesting checker testbench: clock, reset, document stimulus
// and verdict. Depends on mtnc_pkg, the core and mtnc_result_checker.
module tb;
  import mtnc_pkg::*;

  // Number of tag bytes after which the random part stops and the document
  // stream gets one deliberately broken tag.
  localparam int TAG_BYTES = 950;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_HALF,
    RX_SPARSE,
    RX_TOGGLE
  } rx_pattern_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int        mismatches;
  int        outstanding;
  int        results_checked;
  int        deepest;
  err_code_t latched_error;

  // Bookkeeping of the tags the stimulus has opened, so that closing tags can
  // repeat the name that sits on top of the stack.
  logic [7:0] open_text [STACK_DEPTH][MAX_NAME_LEN];
  int         open_len [STACK_DEPTH];
  int         open_depth = 0;
  int         tag_bytes = 0;
  int         burst_left = 0;

  rx_pattern_t rx_mode = RX_FREE;
  int          rx_left = 0;

  always #2 clk = ~clk;

  markup_tag_nesting_checker_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  mtnc_result_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .deepest         (deepest),
    .latched_error   (latched_error)
  );

  // The receiver switches between patterns of random length: always ready,
  // ready half the time, mostly stalled, and strictly alternating. Long free
  // stretches give back-to-back transactions; the sparse pattern fills the
  // output buffer so that in_ready has to drop.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_pattern_t'($urandom_range(3, 0));
      rx_left = $urandom_range(80, 10);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_HALF:   out_ready <= ($urandom_range(1, 0) == 1);
      RX_SPARSE: out_ready <= ($urandom_range(3, 0) == 0);
      default:   out_ready <= ~out_ready;
    endcase
  end

  // Random byte that may stand inside a tag name. A '>' would end the tag, and
  // a '/' right after '<' would turn an opening tag into a closing one.
  function automatic logic [7:0] rand_name_byte(input bit leading);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255, 0));
    end while (b == CHAR_GT || (leading && b == CHAR_SLASH));
    return b;
  endfunction

  // Offers one byte and holds it until the block takes it. The sender works in
  // bursts; when a burst is used up it drops valid for a random gap first.
  task automatic send_byte(input logic [7:0] c, input logic eod);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = $urandom_range(48, 1);
    end
    in_valid <= 1'b1;
    in_data <= '{text_char: c, end_of_doc: eod};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // Opening tag with a random name. Empty and full-length names come often,
  // since both sit at the edge of the name store.
  task automatic send_open(input logic eod);
    int n;
    logic [7:0] b;
    case ($urandom_range(7, 0))
      0:       n = 0;
      1:       n = MAX_NAME_LEN;
      default: n = $urandom_range(MAX_NAME_LEN - 1, 1);
    endcase
    send_byte(CHAR_LT, 1'b0);
    for (int k = 0; k < n; k++) begin
      b = rand_name_byte(k == 0);
      open_text[open_depth][k] = b;
      send_byte(b, 1'b0);
    end
    open_len[open_depth] = n;
    open_depth++;
    send_byte(CHAR_GT, eod);
    tag_bytes += n + 2;
  endtask

  // Closing tag that repeats the name on top of the stack exactly.
  task automatic send_close(input logic eod);
    int top;
    top = open_depth - 1;
    send_byte(CHAR_LT, 1'b0);
    send_byte(CHAR_SLASH, 1'b0);
    for (int k = 0; k < open_len[top]; k++) send_byte(open_text[top][k], 1'b0);
    send_byte(CHAR_GT, eod);
    open_depth--;
    tag_bytes += open_len[top] + 3;
  endtask

  // Holds the sender back until every result has come out. Checked on the
  // falling edge so the checker's bookkeeping of this cycle has settled.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  initial begin
    // Balanced opening sequence: a byte outside any tag, an empty tag pushed
    // and closed by an empty closing tag, then a name holding the byte
    // extremes and the '<' and '/' characters, closed by the same name.
    logic [7:0] intro [19];
    int goal_depth;
    bit paused;
    bit eod;
    int n;
    int k;
    int top;
    logic [7:0] b;
    logic [7:0] bad_name [MAX_NAME_LEN + 1];
    err_code_t ending;

    intro = '{8'hFF, CHAR_LT, CHAR_GT, CHAR_LT, CHAR_SLASH, CHAR_GT,
              CHAR_LT, 8'h00, CHAR_SLASH, CHAR_LT, 8'hFF, CHAR_GT,
              CHAR_LT, CHAR_SLASH, 8'h00, CHAR_SLASH, CHAR_LT,
              8'hFF, CHAR_GT};
    goal_depth = 0;
    paused = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (intro[i]) send_byte(intro[i], i == 18);
    settle();

    // Random documents: the stack wanders toward a random target depth, often
    // the full depth, with stray bytes between tags and the end-of-document
    // flag on some stray bytes and last '>' bytes. Every tag here is well formed,
    // because the first error would freeze the block for the rest of the run.
    while (tag_bytes < TAG_BYTES) begin
      if (open_depth == goal_depth) begin
        goal_depth = ($urandom_range(3, 0) == 0) ? STACK_DEPTH
                                                  : $urandom_range(STACK_DEPTH, 0);
      end
      if ($urandom_range(9, 0) == 0) begin
        do b = 8'($urandom_range(255, 0)); while (b == CHAR_LT);
        send_byte(b, $urandom_range(1, 0));
      end
      eod = ($urandom_range(7, 0) == 0);
      if (open_depth < goal_depth) send_open(eod);
      else if (open_depth > goal_depth) send_close(eod);
      if (!paused && tag_bytes >= TAG_BYTES / 2) begin
        settle();
        paused = 1'b1;
      end
    end

    // The document ends with one broken tag of a random kind, so that each
    // seed exercises one of the error paths and its latching.
    ending = err_code_t'($urandom_range(4, 1));
    case (ending)
      ERR_MISMATCH: begin
        if (open_depth == 0) send_open(1'b0);
        top = open_depth - 1;
        n = open_len[top];
        for (int i = 0; i < n; i++) bad_name[i] = open_text[top][i];
        if (n > 0 && $urandom_range(1, 0) == 1) begin
          if ($urandom_range(1, 0) == 1) begin
            n--;
          end else begin
            k = $urandom_range(n - 1, 0);
            do b = rand_name_byte(1'b0); while (b == bad_name[k]);
            bad_name[k] = b;
          end
        end else if (n < MAX_NAME_LEN) begin
          bad_name[n] = rand_name_byte(1'b0);
          n++;
        end else begin
          n--;
        end
        send_byte(CHAR_LT, 1'b0);
        send_byte(CHAR_SLASH, 1'b0);
        for (int i = 0; i < n; i++) send_byte(bad_name[i], 1'b0);
        send_byte(CHAR_GT, 1'b1);
      end
      ERR_EMPTY: begin
        while (open_depth > 0) send_close(1'b0);
        send_byte(CHAR_LT, 1'b0);
        send_byte(CHAR_SLASH, 1'b1);
      end
      ERR_OVERFLOW: begin
        while (open_depth < STACK_DEPTH) send_open(1'b0);
        send_byte(CHAR_LT, 1'b0);
        send_byte(rand_name_byte(1'b1), 1'b1);
      end
      default: begin
        // Name one byte longer than the store holds, in a closing tag when
        // one is possible and the coin says so, else in an opening tag.
        if (open_depth > 0 && $urandom_range(1, 0) == 1) begin
          send_byte(CHAR_LT, 1'b0);
          send_byte(CHAR_SLASH, 1'b0);
        end else begin
          if (open_depth == STACK_DEPTH) send_close(1'b0);
          send_byte(CHAR_LT, 1'b0);
        end
        for (int i = 0; i <= MAX_NAME_LEN; i++) send_byte(rand_name_byte(i == 0), 1'b0);
      end
    endcase

    // Bytes after the error, tag characters included, must leave the latched
    // status and the depth untouched.
    repeat (16) begin
      case ($urandom_range(3, 0))
        0:       b = CHAR_LT;
        1:       b = CHAR_SLASH;
        2:       b = CHAR_GT;
        default: b = 8'($urandom_range(255, 0));
      endcase
      send_byte(b, $urandom_range(1, 0));
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Checked %0d results over balanced documents up to depth %0d;",
             results_checked, deepest);
    $display("the closing broken tag latched status %s.", latched_error.name());
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
